// File: src/frame_time_window_stats_top_defines.svh
// assertion macros for the frame time window stats block
`ifndef FRAME_TIME_WINDOW_STATS_TOP_DEFINES_SVH
`define FRAME_TIME_WINDOW_STATS_TOP_DEFINES_SVH

// implication checked at every rising edge outside reset
`define FTWS_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error(msg);

// next-cycle implication
`define FTWS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error(msg);

`endif

// File: src/ftws_pkg.sv
package ftws_pkg;

    localparam int unsigned TimeW  = 24;
    localparam int unsigned LowDiv = 100;

    // count / 100 as multiply and shift, exact for counts up to 4096
    localparam int unsigned LowRecip = 5243;
    localparam int unsigned LowShift = 19;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic store;      // write the input sample into the ring
        logic scan_start; // clear accumulators, start the pass
        logic scan_step;  // one ring entry per cycle
        logic rank_start; // begin candidate pass
        logic rank_step;
        logic div_start;
        logic div_step;
        logic load_out;
    } t_ctrl;

    // datapath to controller
    typedef struct packed {
        logic empty;
        logic scan_last;  // index reaches the last held entry
        logic rank_done;  // selected value found or all candidates tried
        logic div_done;
    } t_stat;

endpackage

// File: src/ftws_datapath.sv
module ftws_datapath #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ftws_pkg::t_ctrl                 i_ctrl,
    input  logic [ftws_pkg::TimeW-1:0]      i_sample,
    output ftws_pkg::t_stat                 o_stat,
    output logic [ftws_pkg::TimeW-1:0]      o_mean,
    output logic [ftws_pkg::TimeW-1:0]      o_min,
    output logic [ftws_pkg::TimeW-1:0]      o_max,
    output logic [ftws_pkg::TimeW-1:0]      o_low,
    output logic [$clog2(DEPTH+1)-1:0]      o_count
);
    localparam int unsigned AW  = $clog2(DEPTH);
    localparam int unsigned CW  = $clog2(DEPTH+1);
    localparam int unsigned TW  = ftws_pkg::TimeW;
    localparam int unsigned SW  = TW + AW;
    localparam int unsigned DCW = $clog2(TW+1);
    localparam int unsigned KW  = CW + 13;

    logic [TW-1:0] mem [DEPTH];

    logic [AW-1:0] r_wpos, n_wpos;
    logic [CW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_idx;      // inner scan index
    logic [AW-1:0] r_cand;     // candidate index (outer loop)
    logic [TW-1:0] r_rd;       // registered read data
    logic [TW-1:0] r_cval;     // candidate value
    logic          r_rd_vld;
    logic [SW-1:0] r_sum;
    logic [TW-1:0] r_min, r_max;
    logic [CW-1:0] r_gt, r_ge;
    logic [CW-1:0] r_k;
    logic          r_found;
    logic [TW-1:0] r_low;
    logic [SW-1:0] r_rem;
    logic [TW-1:0] r_quo;
    logic [DCW-1:0] r_dcnt;
    logic [TW-1:0] r_mean_o, r_min_o, r_max_o, r_low_o;
    logic [CW-1:0] r_cnt_o;
    logic          r_phase;    // 0: read candidate, 1: compare sweep
    logic [AW-1:0] last_idx;
    logic [AW-1:0] rd_addr;
    logic [SW:0]   trial;
    logic [KW-1:0] k_prod;
    logic [AW-1:0] r_cmp_idx;
    logic          sweep_end;
    logic [CW-1:0] gt_f, ge_f;
    logic          r_seen_last;
    logic          r_scan_seen;

    assign n_wpos = (r_wpos == AW'(DEPTH-1)) ? '0 : r_wpos + 1'b1;
    assign n_fill = (r_fill == CW'(DEPTH)) ? r_fill : r_fill + 1'b1;
    assign last_idx = AW'(r_fill - 1'b1);
    assign k_prod = KW'(r_fill) * KW'(ftws_pkg::LowRecip);

    // ring write, one registered read port
    assign rd_addr = (i_ctrl.rank_step && !r_phase) ? r_cand : r_idx;
    always_ff @(posedge i_clk) begin
        if (i_ctrl.store) begin
            mem[r_wpos] <= i_sample;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
        end else if (i_ctrl.store) begin
            r_wpos <= n_wpos;
            r_fill <= n_fill;
        end
    end

    // divider remainder shifted into position
    assign trial = {r_rem, 1'b0} - ({{(SW+1-CW){1'b0}}, r_fill} << TW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
            r_phase  <= 1'b0;
            r_found  <= 1'b0;
        end else begin
            if (i_ctrl.scan_start) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_sum    <= '0;
                r_min    <= '1;
                r_max    <= '0;
            end else if (i_ctrl.scan_step) begin
                r_rd_vld <= 1'b1;
                if (r_idx != last_idx) r_idx <= r_idx + 1'b1;
                if (r_rd_vld) begin
                    r_sum <= r_sum + SW'(r_rd);
                    if (r_rd < r_min) r_min <= r_rd;
                    if (r_rd > r_max) r_max <= r_rd;
                end
            end
            if (i_ctrl.rank_start) begin
                r_cand  <= '0;
                r_phase <= 1'b0;
                r_found <= 1'b0;
                r_k     <= CW'(k_prod >> ftws_pkg::LowShift);
                r_low   <= '0;
            end else if (i_ctrl.rank_step) begin
                if (!r_phase) begin
                    // candidate read issued this cycle, sweep starts at 0
                    r_phase  <= 1'b1;
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    r_gt     <= '0;
                    r_ge     <= '0;
                end else if (!r_rd_vld) begin
                    r_cval   <= r_rd;
                    r_rd_vld <= 1'b1;
                    r_idx    <= (r_idx != last_idx) ? r_idx + 1'b1 : r_idx;
                end else begin
                    if (r_rd > r_cval)  r_gt <= r_gt + 1'b1;
                    if (r_rd >= r_cval) r_ge <= r_ge + 1'b1;
                    if (r_idx != last_idx) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            if (i_ctrl.rank_step && r_phase && r_rd_vld && sweep_end) begin
                if (gt_f <= r_k && r_k < ge_f) begin
                    r_found <= 1'b1;
                    r_low   <= r_cval;
                end
                r_phase <= 1'b0;
                r_cand  <= r_cand + 1'b1;
            end
            if (i_ctrl.div_start) begin
                r_rem  <= r_sum;
                r_quo  <= '0;
                r_dcnt <= '0;
            end else if (i_ctrl.div_step) begin
                if (!trial[SW]) begin
                    r_rem <= trial[SW-1:0];
                    r_quo <= {r_quo[TW-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[SW-2:0], 1'b0};
                    r_quo <= {r_quo[TW-2:0], 1'b0};
                end
                r_dcnt <= r_dcnt + 1'b1;
            end
        end
    end

    // sweep bookkeeping: the entry under compare is the one read last cycle
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
    end
    assign sweep_end = r_cmp_idx == last_idx && r_rd_vld && r_phase
                       && r_idx == last_idx && r_seen_last;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_last <= 1'b0;
        end else if (!r_phase || !r_rd_vld) begin
            r_seen_last <= 1'b0;
        end else if (i_ctrl.rank_step && r_idx == last_idx) begin
            r_seen_last <= 1'b1;
        end
    end
    assign gt_f = r_gt + CW'(r_rd > r_cval);
    assign ge_f = r_ge + CW'(r_rd >= r_cval);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_out) begin
            r_cnt_o  <= r_fill;
            if (r_fill == '0) begin
                r_mean_o <= '0;
                r_min_o  <= '0;
                r_max_o  <= '0;
                r_low_o  <= '0;
            end else begin
                r_mean_o <= r_quo;
                r_min_o  <= r_min;
                r_max_o  <= r_max;
                r_low_o  <= r_low;
            end
        end
    end

    assign o_stat.empty     = (r_fill == '0);
    assign o_stat.scan_last = r_rd_vld && r_cmp_idx == last_idx && r_idx == last_idx
                              && r_scan_seen;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.scan_start) begin
            r_scan_seen <= 1'b0;
        end else if (i_ctrl.scan_step && r_idx == last_idx) begin
            r_scan_seen <= 1'b1;
        end
    end
    assign o_stat.rank_done = r_found
                              || (r_cand == last_idx && sweep_end && i_ctrl.rank_step);
    assign o_stat.div_done  = r_dcnt == DCW'(TW);

    assign o_mean  = r_mean_o;
    assign o_min   = r_min_o;
    assign o_max   = r_max_o;
    assign o_low   = r_low_o;
    assign o_count = r_cnt_o;
endmodule

// File: src/ftws_ctrl.sv
module ftws_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_acc,
    input  logic            i_opcode,
    input  logic            i_out_acc,
    input  ftws_pkg::t_stat i_stat,
    output ftws_pkg::t_ctrl o_ctrl,
    output logic            o_in_ready,
    output logic            o_out_valid
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCAN = 7'b0000010,
        S_RNK0 = 7'b0000100,
        S_RANK = 7'b0001000,
        S_DIV0 = 7'b0010000,
        S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_valid, n_valid;

    always_comb begin
        n_state = r_state;
        n_valid = r_valid;
        o_ctrl  = '0;
        if (i_out_acc) n_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_acc) begin
                    if (i_opcode == ftws_pkg::OP_RECORD) begin
                        o_ctrl.store = 1'b1;
                    end else if (i_stat.empty) begin
                        n_state = S_OUT;
                    end else begin
                        o_ctrl.scan_start = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_ctrl.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_RNK0;
            end
            S_RNK0: begin
                o_ctrl.rank_start = 1'b1;
                n_state = S_RANK;
            end
            S_RANK: begin
                o_ctrl.rank_step = 1'b1;
                if (i_stat.rank_done) n_state = S_DIV0;
            end
            S_DIV0: begin
                o_ctrl.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_ctrl.div_step = !i_stat.div_done;
                if (i_stat.div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_valid || i_out_acc) begin
                    o_ctrl.load_out = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_valid;
endmodule

// File: src/frame_time_window_stats_top.sv
// channel   | dir | fields (tdata low bit first)
// s_axis    | in  | tuser: opcode; tdata: sample_time[23:0]
// m_axis    | out | tdata: mean, min, max, low_percentile (24 each), held_count (9), pad
// a record is written into the ring as it is accepted; a report's run time is set
// by the candidate-rank sweep over the ring's single read port. reset clears
// position, count, handshake state and the scan and rank flags only.
// a finished report waits in the output register while records keep flowing
`include "frame_time_window_stats_top_defines.svh"
module frame_time_window_stats_top #(
    parameter int unsigned HISTORY_DEPTH = 256
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,  // sample_time
    input  logic         s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata   // mean, min, max, low, count, zero pad
);
    localparam int unsigned CW = $clog2(HISTORY_DEPTH+1);

    ftws_pkg::t_ctrl ctrl;
    ftws_pkg::t_stat stat;
    logic in_acc, out_acc;
    logic [23:0] mean_t, min_t, max_t, low_t;
    logic [CW-1:0] cnt;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    ftws_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_acc(in_acc), .i_opcode(s_axis_tuser),
        .i_out_acc(out_acc), .i_stat(stat), .o_ctrl(ctrl), .o_in_ready(s_axis_tready),
        .o_out_valid(m_axis_tvalid)
    );

    ftws_datapath #(.DEPTH(HISTORY_DEPTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctrl(ctrl), .i_sample(s_axis_tdata),
        .o_stat(stat), .o_mean(mean_t), .o_min(min_t), .o_max(max_t), .o_low(low_t),
        .o_count(cnt)
    );

    assign m_axis_tdata = {7'b0, 9'(cnt), low_t, max_t, min_t, mean_t};

    `FTWS_ASSERT_IMPL(a_min_le_max, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[47:24] <= m_axis_tdata[71:48] || m_axis_tdata[104:96] == '0,
        "report min above max")
    `FTWS_ASSERT_NEXT(a_busy_no_ready, i_clk, i_rst_n,
        in_acc && s_axis_tuser == ftws_pkg::OP_REPORT, !s_axis_tready,
        "report accepted but input still ready")
    `FTWS_ASSERT_IMPL(a_one_ctrl, i_clk, i_rst_n, 1'b1,
        $countones({ctrl.store, ctrl.scan_step, ctrl.rank_step, ctrl.div_step}) <= 1,
        "overlapping datapath commands")
endmodule
